// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the list engine modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define OALE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define OALE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/oale_pkg.sv =====
// ----------------------------------------------------------------------------
// oale_pkg
// Codes and controller/datapath interface types for the ordered list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oale_pkg;

  localparam logic [1:0] MODE_INS  = 2'd0;
  localparam logic [1:0] MODE_DEL  = 2'd1;
  localparam logic [1:0] MODE_SRCH = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic load;    // capture operation
    logic walk;    // step through entries
    logic put;     // write inserted value
    logic commit;  // update count, load result register
  } cmd_t;

  typedef struct packed {
    logic done;      // walk finished or search hit
    logic need_put;  // valid insert awaiting final write
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/oale_ctrl.sv =====
// ----------------------------------------------------------------------------
// oale_ctrl
// Sequencer: accepts one operation, drives the datapath walk, hands the result
// to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module oale_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire oale_pkg::sts_t sts,
  output oale_pkg::cmd_t     cmd
);
  import oale_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PUT,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.walk   = (state_r == S_WALK);
  assign cmd.put    = (state_r == S_PUT);
  assign cmd.commit = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_WALK;
        end
        S_WALK: begin
          if (sts.done) state_r <= sts.need_put ? S_PUT : S_FINISH;
        end
        S_PUT: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `OALE_ASSERT(a_commit_shows, clk, rst_n, cmd.commit |=> out_valid_r, "result not presented")
  `OALE_ASSERT(a_accept_busy, clk, rst_n, cmd.load |=> !in_ready, "accepted twice")
  `OALE_ASSERT(a_put_finish, clk, rst_n, cmd.put |=> (state_r == S_FINISH), "put not followed by finish")

endmodule

`default_nettype wire

// ===== hdl/oale_dp.sv =====
// ----------------------------------------------------------------------------
// oale_dp
// Datapath: entry memory, walk address and remaining counters, count register
// and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module oale_dp #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire oale_pkg::cmd_t     cmd,
  output oale_pkg::sts_t          sts,
  input  wire logic [1:0]         in_mode,
  input  wire logic [CW-1:0]      in_position,
  input  wire logic signed [31:0] in_value,
  output logic [1:0]              out_status,
  output logic [AW-1:0]           out_found_position,
  output logic [CW-1:0]           out_entry_count
);
  import oale_pkg::*;

  logic signed [31:0] mem_r [DEPTH];

  logic [1:0]         mode_r;
  logic [CW-1:0]      pos_r;
  logic signed [31:0] val_r;
  logic [1:0]         st_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      cnt_nxt;
  logic [CW-1:0]      rem_r;
  logic [AW-1:0]      addr_r;
  logic [AW-1:0]      rd_addr_r;
  logic signed [31:0] rdata_r;
  logic               rdv_r;
  logic               hit_r;
  logic [AW-1:0]      found_r;

  logic [1:0]         ld_st;
  logic [CW-1:0]      ld_rem;
  logic [AW-1:0]      ld_addr;

  logic               is_ins;
  logic               is_del;
  logic               is_srch;
  logic               rd_en;
  logic               hit;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic [1:0]         res_st;

  assign is_ins  = (mode_r == MODE_INS);
  assign is_del  = (mode_r == MODE_DEL);
  assign is_srch = (mode_r == MODE_SRCH);

  always_comb begin
    ld_st   = ST_OK;
    ld_rem  = '0;
    ld_addr = '0;
    case (in_mode)
      MODE_INS: begin
        if (cnt_r == CW'(DEPTH)) begin
          ld_st = ST_FULL;
        end else if (in_position > cnt_r) begin
          ld_st = ST_RANGE;
        end else begin
          ld_rem  = cnt_r - in_position;
          ld_addr = AW'(cnt_r - 1'b1);
        end
      end
      MODE_DEL: begin
        if (in_position >= cnt_r) begin
          ld_st = ST_RANGE;
        end else begin
          ld_rem  = cnt_r - in_position - 1'b1;
          ld_addr = AW'(in_position + 1'b1);
        end
      end
      MODE_SRCH: begin
        ld_rem = cnt_r;
      end
      default: ld_rem = '0;
    endcase
  end

  assign rd_en   = cmd.walk && (rem_r != '0);
  assign hit     = cmd.walk && rdv_r && is_srch && (rdata_r == val_r);
  assign wr_en   = cmd.put || (cmd.walk && rdv_r && (is_ins || is_del));
  assign wr_addr = cmd.put ? pos_r[AW-1:0] :
                   (is_ins ? rd_addr_r + 1'b1 : rd_addr_r - 1'b1);
  assign wr_data = cmd.put ? val_r : rdata_r;

  assign sts.done     = hit || ((rem_r == '0) && !rdv_r);
  assign sts.need_put = is_ins && (st_r == ST_OK);

  always_comb begin
    res_st  = st_r;
    cnt_nxt = cnt_r;
    if (st_r == ST_OK) begin
      if (is_srch && !hit_r) res_st = ST_NOTFOUND;
      if (is_ins) cnt_nxt = cnt_r + 1'b1;
      if (is_del) cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rdv_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      rdv_r <= rd_en;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.commit) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      pos_r   <= in_position;
      val_r   <= in_value;
      st_r    <= ld_st;
      rem_r   <= ld_rem;
      addr_r  <= ld_addr;
      found_r <= '0;
    end else begin
      if (rd_en) begin
        rd_addr_r <= addr_r;
        addr_r    <= is_ins ? addr_r - 1'b1 : addr_r + 1'b1;
        rem_r     <= rem_r - 1'b1;
      end
      if (hit) found_r <= rd_addr_r;
    end
    if (cmd.commit) begin
      out_status         <= res_st;
      out_found_position <= found_r;
      out_entry_count    <= cnt_nxt;
    end
  end

  `OALE_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH), "count above depth")
  `OALE_ASSERT(a_put_in_range, clk, rst_n, cmd.put |-> (pos_r <= cnt_r) && (cnt_r < CW'(DEPTH)),
               "insert position out of range")
  `OALE_ASSERT(a_err_no_write, clk, rst_n, (st_r != ST_OK) && cmd.walk |-> !wr_en,
               "write on rejected operation")

endmodule

`default_nettype wire

// ===== hdl/ordered_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Dense ordered list of signed 32-bit values: insert, delete and search.
// ----------------------------------------------------------------------------
//  channel  ports                                      direction
//  in       in_valid/in_ready, in_mode/position/value  operation in
//  out      out_valid/out_ready, out_status/found/count result out
//
//  One operation at a time; one memory entry is moved or compared per cycle.
//  A pending result waits in the output register; the next operation is
//  taken meanwhile and waits only at its own result transfer.
//  Synchronous active-low reset empties the list; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_list_engine #(
  parameter int DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_mode,
  input  wire logic [$clog2(DEPTH + 1)-1:0]   in_position,
  input  wire logic signed [31:0]             in_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          out_status,
  output logic [$clog2(DEPTH)-1:0]            out_found_position,
  output logic [$clog2(DEPTH + 1)-1:0]        out_entry_count
);
  import oale_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t cmd;
  sts_t sts;

  oale_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  oale_dp #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_mode),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count)
  );

endmodule

`default_nettype wire

// ===== tb/oale_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oale_checker
// Watches both channels of the ordered list engine. Every operation taken on
// the input side is applied to a local copy of the list, and the expected
// status, found position and entry count are queued. Each result transfer
// is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------

module oale_checker #(
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [$clog2(DEPTH + 1)-1:0]  in_position,
  input  wire logic signed [31:0]            in_value,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [1:0]                    out_status,
  input  wire logic [$clog2(DEPTH)-1:0]      out_found_position,
  input  wire logic [$clog2(DEPTH + 1)-1:0]  out_entry_count,
  output int                                 mismatches,
  output int                                 pending
);
  import oale_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);
  localparam int FW = $clog2(DEPTH);

  typedef struct packed {
    logic [1:0]    status;
    logic [FW-1:0] found;
    logic [PW-1:0] count;
  } list_result_t;

  logic signed [31:0] list_mem [DEPTH];
  int                 list_len;
  list_result_t       result_q [$];
  list_result_t       got;
  list_result_t       want;
  int                 err_cnt = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
    list_len   = 0;
  end

  // apply one operation to the local list and work out its result
  task automatic apply_op(input logic [1:0] mode, input logic [PW-1:0] pos,
                          input logic signed [31:0] val, output list_result_t r);
    int i;
    r.status = ST_OK;
    r.found  = '0;
    case (mode)
      MODE_INS: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (int'(pos) > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = list_len; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
          list_mem[pos[FW-1:0]] = val;
          list_len++;
        end
      end
      MODE_DEL: begin
        if (int'(pos) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      MODE_SRCH: begin
        r.status = ST_NOTFOUND;
        // scan downwards so the lowest matching slot wins
        for (i = list_len - 1; i >= 0; i--) begin
          if (list_mem[i] == val) begin
            r.status = ST_OK;
            r.found  = i[FW-1:0];
          end
        end
      end
      default: ;
    endcase
    r.count = list_len[PW-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      result_q.delete();
      list_len = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.status = out_status;
        got.found  = out_found_position;
        got.count  = out_entry_count;
        if (result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result transfer: status %0d found %0d count %0d",
                     $realtime, got.status, got.found, got.count);
        end else begin
          want = result_q.pop_front();
          if (got.status != want.status || got.found != want.found ||
              got.count != want.count) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: result mismatch: status %0d/%0d found %0d/%0d count %0d/%0d",
                       $realtime, want.status, got.status, want.found, got.found,
                       want.count, got.count);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_op(in_mode, in_position, in_value, want);
        result_q.push_back(want);
      end
    end
    pending    <= result_q.size();
    mismatches <= err_cnt;
  end

endmodule

// ===== tb/tb_ordered_array_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_array_list_engine
// Drives list operations into the engine: a directed pass over empty, full
// and out-of-range cases, then random operation streams that grow and shrink
// the list with values drawn largely from a small pool so searches hit.
// Both sides idle at random; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------

module tb_ordered_array_list_engine;
  import oale_pkg::*;

  localparam int DEPTH = 16;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int FW    = $clog2(DEPTH);
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int N_RANDOM = 1420;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_mode = MODE_INS;
  logic [PW-1:0]       in_position = '0;
  logic signed [31:0]  in_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_status;
  logic [FW-1:0]       out_found_position;
  logic [PW-1:0]       out_entry_count;
  int                  mismatches;
  int                  pending;

  int                  list_len = 0;
  bit                  no_idle = 1'b0;
  bit                  growing = 1'b1;
  logic signed [31:0]  value_pool [8] = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh0, -32'sd1,
                                          32'sd1, 32'sh12345678, 32'sh55555555,
                                          32'shAAAAAAAA};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ordered_array_list_engine #(.DEPTH(DEPTH)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count)
  );

  oale_checker #(.DEPTH(DEPTH)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one operation transfer; called at a rising edge
  task automatic send_op(input logic [1:0] mode, input logic [PW-1:0] pos,
                         input logic signed [31:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (!in_ready);
    // track the length only, to aim positions at the legal range
    if (mode == MODE_INS && list_len < DEPTH && int'(pos) <= list_len) list_len++;
    if (mode == MODE_DEL && int'(pos) < list_len) list_len--;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_op();
    int r;
    logic [1:0] mode;
    logic [PW-1:0] pos;
    logic signed [31:0] val;
    if (list_len == DEPTH) growing = 1'b0;
    else if (list_len == 0) growing = 1'b1;
    else if ($urandom_range(0, 99) < 2) growing = !growing;
    r = $urandom_range(0, 99);
    if (growing)
      mode = (r < 55) ? MODE_INS : (r < 75) ? MODE_DEL : (r < 95) ? MODE_SRCH : MODE_NOP;
    else
      mode = (r < 20) ? MODE_INS : (r < 55) ? MODE_DEL : (r < 95) ? MODE_SRCH : MODE_NOP;
    r = $urandom_range(0, 99);
    if (r < 10)
      pos = PW'($urandom_range(0, 31));
    else if (mode == MODE_DEL && list_len > 0)
      pos = PW'($urandom_range(0, list_len - 1));
    else
      pos = PW'($urandom_range(0, list_len));
    if ($urandom_range(0, 99) < 65) val = value_pool[$urandom_range(0, 7)];
    else val = $urandom;
    send_op(mode, pos, val);
  endtask

  initial begin
    forever begin
      int n;
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list cases and the unused mode
    send_op(MODE_SRCH, 5'd0, 32'sd7);
    send_op(MODE_DEL, 5'd0, 32'sd0);
    send_op(MODE_INS, 5'd1, 32'sd3);
    send_op(MODE_NOP, 5'd31, -32'sd1);
    // front, append, and extreme values
    send_op(MODE_INS, 5'd0, 32'sh80000000);
    send_op(MODE_INS, 5'd1, 32'sh7FFFFFFF);
    send_op(MODE_INS, 5'd0, -32'sd1);
    send_op(MODE_SRCH, 5'd31, -32'sd1);
    send_op(MODE_SRCH, 5'd0, 32'sh7FFFFFFF);
    send_op(MODE_SRCH, 5'd0, 32'sd7);
    send_op(MODE_DEL, 5'd3, 32'sd0);
    send_op(MODE_INS, 5'd31, 32'sd9);
    // fill up, leaving a unique value in the top slot
    while (list_len < DEPTH - 1)
      send_op(MODE_INS, PW'($urandom_range(0, list_len)), value_pool[$urandom_range(0, 7)]);
    send_op(MODE_INS, 5'd15, 32'sh5A5A5A5A);
    send_op(MODE_INS, 5'd31, 32'sd4);
    send_op(MODE_SRCH, 5'd0, 32'sh5A5A5A5A);
    send_op(MODE_DEL, 5'd16, 32'sd0);
    send_op(MODE_DEL, 5'd15, 32'sd0);
    send_op(MODE_DEL, 5'd0, 32'sd0);
    wait_drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 600 && i < 800);
      if (i % 350 == 349) wait_drain();
      random_op();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
